// ----- rtl/core/pmab_pkg.sv -----
// ----------------------------------------------------------------------------
// pmab_pkg
// Shared types and constants for the premultiplied alpha over blender.
// ----------------------------------------------------------------------------
package pmab_pkg;

    localparam int NUM_LANES  = 4;
    localparam int CHANNELS   = 4;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = CHANNELS * CHAN_W;
    localparam int GAIN_W     = 9;
    localparam int PROD_W     = 17;   // gain * channel, at most 65280
    localparam int NUM_W      = 25;   // full blend numerator, below 2^25

    localparam logic [GAIN_W-1:0] GAIN_ONE    = 9'd256;
    localparam logic [PROD_W-1:0] BLEND_DENOM = 17'd65280;  // 256 * 255
    localparam logic [NUM_W:0]    ROUND_HALF  = 26'd32640;
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;

    // Load enables of the three pipeline stages: operand products,
    // numerator, merged output register.
    typedef struct packed {
        logic en_prod;
        logic en_num;
        logic en_out;
    } t_pipe_ctl;

endpackage

// ----- rtl/core/pmab_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmab_ctrl
// Valid tracking and stall propagation for the three-stage blend pipeline.
// ----------------------------------------------------------------------------
module pmab_ctrl
    import pmab_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_pipe_ctl o_ctl
);

    logic r_v_prod;
    logic r_v_num;
    logic r_v_out;
    logic w_rdy_prod;
    logic w_rdy_num;
    logic w_rdy_out;

    // A stage may load when it is empty or its content moves on this cycle.
    assign w_rdy_out  = !r_v_out  || !i_out_stall;
    assign w_rdy_num  = !r_v_num  || w_rdy_out;
    assign w_rdy_prod = !r_v_prod || w_rdy_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_num  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (w_rdy_prod) begin
                r_v_prod <= i_in_valid;
            end
            if (w_rdy_num) begin
                r_v_num <= r_v_prod;
            end
            if (w_rdy_out) begin
                r_v_out <= r_v_num;
            end
        end
    end

    assign o_in_stall    = !w_rdy_prod;
    assign o_out_valid   = r_v_out;
    assign o_ctl.en_prod = w_rdy_prod;
    assign o_ctl.en_num  = w_rdy_num;
    assign o_ctl.en_out  = w_rdy_out;

endmodule

// ----- rtl/core/pmab_chan.sv -----
// ----------------------------------------------------------------------------
// pmab_chan
// One colour channel of one lane: premultiplied over with global gain,
// rounded to nearest and saturated at 255.
// ----------------------------------------------------------------------------
module pmab_chan
    import pmab_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_ctl         i_ctl,
    input  logic [GAIN_W-1:0] i_gain,
    input  logic [CHAN_W-1:0] i_src,
    input  logic [CHAN_W-1:0] i_src_alpha,
    input  logic [CHAN_W-1:0] i_dst,
    output logic [CHAN_W-1:0] o_blend
);

    logic [PROD_W-1:0] r_gain_alpha;
    logic [PROD_W-1:0] r_gain_src;
    logic [CHAN_W-1:0] r_dst;
    logic [NUM_W-1:0]  r_num;

    logic [PROD_W-1:0] w_keep;
    logic [NUM_W-1:0]  n_num;
    logic [NUM_W:0]    w_rounded;
    logic [17:0]       w_scaled;
    logic [15:0]       w_low;
    logic [16:0]       w_div_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            r_gain_alpha <= PROD_W'(i_gain) * PROD_W'(i_src_alpha);
            r_gain_src   <= PROD_W'(i_gain) * PROD_W'(i_src);
            r_dst        <= i_dst;
        end
    end

    // Numerator over 65280: d*(65280 - m*sa) + m*s*255.
    assign w_keep = BLEND_DENOM - r_gain_alpha;
    assign n_num  = NUM_W'(r_dst) * NUM_W'(w_keep)
                  + ((NUM_W'(r_gain_src) << 8) - NUM_W'(r_gain_src));

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_num) begin
            r_num <= n_num;
        end
    end

    // Divide by 256 then by 255; quotients of 255 and above saturate.
    assign w_rounded = (NUM_W+1)'(r_num) + ROUND_HALF;
    assign w_scaled  = w_rounded[NUM_W:8];
    assign w_low     = w_scaled[15:0];
    assign w_div_sum = 17'(w_low) + 17'(w_low[15:8]) + 17'd1;

    always_comb begin
        if (w_scaled >= 18'(BLEND_DENOM)) begin
            o_blend = CHAN_MAX;
        end else begin
            o_blend = w_div_sum[15:8];
        end
    end

endmodule

// ----- rtl/core/premultiplied_alpha_blend_x4_top.sv -----
// ----------------------------------------------------------------------------
// premultiplied_alpha_blend_x4_top
// Four-lane ARGB8888 premultiplied alpha over compositor with global gain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry a request of four source
//   and four destination pixels. Output channel: o_out_valid / i_out_stall
//   return the four blended pixels, one result per request, in order.
//   i_cfg_we / i_cfg_data write the 9-bit alpha gain (256 means unity);
//   values above 256 are clamped to 256. Write it only while idle.
// Path: an accepted request passes the product stage, the numerator stage
//   and the merged output register before it reaches o_out_valid.
// Throughput: one request per cycle unless stalled; the sixteen channel units run side by
//   side, each with one multiplier stage followed by one multiply-add stage.
// Reset: clears all valid flags and sets the gain to 256.
// Stall: while i_out_stall holds a result, earlier stages keep filling any
//   empty slot; o_in_stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
module premultiplied_alpha_blend_x4_top
    import pmab_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GAIN_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [31:0]       i_src_pixel_0,
    input  logic [31:0]       i_src_pixel_1,
    input  logic [31:0]       i_src_pixel_2,
    input  logic [31:0]       i_src_pixel_3,
    input  logic [31:0]       i_dst_pixel_0,
    input  logic [31:0]       i_dst_pixel_1,
    input  logic [31:0]       i_dst_pixel_2,
    input  logic [31:0]       i_dst_pixel_3,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [31:0]       o_out_pixel_0,
    output logic [31:0]       o_out_pixel_1,
    output logic [31:0]       o_out_pixel_2,
    output logic [31:0]       o_out_pixel_3
);

    logic [GAIN_W-1:0]                  r_gain;
    t_pipe_ctl                          w_ctl;
    logic [NUM_LANES-1:0][PIXEL_W-1:0]  w_src;
    logic [NUM_LANES-1:0][PIXEL_W-1:0]  w_dst;
    logic [NUM_LANES-1:0][PIXEL_W-1:0]  w_blend;
    logic [NUM_LANES-1:0][PIXEL_W-1:0]  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
        end else if (i_cfg_we) begin
            r_gain <= (i_cfg_data > GAIN_ONE) ? GAIN_ONE : i_cfg_data;
        end
    end

    assign w_src[0] = i_src_pixel_0;
    assign w_src[1] = i_src_pixel_1;
    assign w_src[2] = i_src_pixel_2;
    assign w_src[3] = i_src_pixel_3;
    assign w_dst[0] = i_dst_pixel_0;
    assign w_dst[1] = i_dst_pixel_1;
    assign w_dst[2] = i_dst_pixel_2;
    assign w_dst[3] = i_dst_pixel_3;

    pmab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (w_ctl)
    );

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
            pmab_chan u_chan (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_gain      (r_gain),
                .i_src       (w_src[l][c*CHAN_W +: CHAN_W]),
                .i_src_alpha (w_src[l][PIXEL_W-1 -: CHAN_W]),
                .i_dst       (w_dst[l][c*CHAN_W +: CHAN_W]),
                .o_blend     (w_blend[l][c*CHAN_W +: CHAN_W])
            );
        end
    end

    // Merge all lanes into one output word; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (w_ctl.en_out) begin
            r_out <= w_blend;
        end
    end

    assign o_out_pixel_0 = r_out[0];
    assign o_out_pixel_1 = r_out[1];
    assign o_out_pixel_2 = r_out[2];
    assign o_out_pixel_3 = r_out[3];

endmodule

// ----- tb/sv/premultiplied_alpha_blend_x4_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// premultiplied_alpha_blend_x4_checker
// Watches the input and output channels of the four-lane over compositor, computes
// the blended pixels of every accepted request with its own copy of the
// alpha gain, and compares each returned result lane by lane, in order.
// ----------------------------------------------------------------------------
module premultiplied_alpha_blend_x4_checker
    import pmab_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [GAIN_W-1:0]                 i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [NUM_LANES-1:0][PIXEL_W-1:0] i_src_pixels,
    input  logic [NUM_LANES-1:0][PIXEL_W-1:0] i_dst_pixels,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [NUM_LANES-1:0][PIXEL_W-1:0] i_out_pixels,
    output int                                o_mismatch_count,
    output int                                o_results_pending
);

    typedef logic [NUM_LANES-1:0][PIXEL_W-1:0] t_lane_pixels;

    t_lane_pixels blended_q[$];
    int unsigned  gain_copy;
    int           mismatches = 0;
    int           pending    = 0;
    int           results_seen = 0;

    assign o_mismatch_count  = mismatches;
    assign o_results_pending = pending;

    // Exact over rule on one channel: round half up, then clip to 255.
    function automatic logic [CHAN_W-1:0] mix_channel(input int unsigned src_c,
                                                      input int unsigned dst_c,
                                                      input int unsigned src_a,
                                                      input int unsigned gain);
        int unsigned keep;
        int unsigned numer;
        int unsigned quot;
        keep  = BLEND_DENOM - gain * src_a;
        numer = dst_c * keep + gain * src_c * CHAN_MAX;
        quot  = (numer + ROUND_HALF) / BLEND_DENOM;
        return (quot > CHAN_MAX) ? CHAN_MAX : quot[CHAN_W-1:0];
    endfunction

    function automatic logic [PIXEL_W-1:0] composite_pixel(input logic [PIXEL_W-1:0] src,
                                                           input logic [PIXEL_W-1:0] dst,
                                                           input int unsigned gain);
        logic [PIXEL_W-1:0] mixed;
        int unsigned        src_a;
        src_a = 32'(src[PIXEL_W-1 -: CHAN_W]);
        for (int ch = 0; ch < CHANNELS; ch++) begin
            mixed[ch*CHAN_W +: CHAN_W] = mix_channel(32'(src[ch*CHAN_W +: CHAN_W]),
                                                     32'(dst[ch*CHAN_W +: CHAN_W]),
                                                     src_a, gain);
        end
        return mixed;
    endfunction

    task automatic report_mismatch(input string msg);
        // keep the log short when everything breaks
        if (mismatches < 40) begin
            $display("%0t: ERROR %s", $realtime, msg);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_lane_pixels blended;
        t_lane_pixels wanted;
        if (!i_rst_n) begin
            gain_copy = 32'(GAIN_ONE);
            blended_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                for (int ln = 0; ln < NUM_LANES; ln++) begin
                    blended[ln] = composite_pixel(i_src_pixels[ln], i_dst_pixels[ln],
                                                  gain_copy);
                end
                blended_q.push_back(blended);
            end
            if (i_out_valid && !i_out_stall) begin
                if (blended_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              results_seen));
                end else begin
                    wanted = blended_q.pop_front();
                    for (int ln = 0; ln < NUM_LANES; ln++) begin
                        if (i_out_pixels[ln] !== wanted[ln]) begin
                            report_mismatch($sformatf("result %0d lane %0d: got %08h want %08h",
                                                      results_seen, ln, i_out_pixels[ln],
                                                      wanted[ln]));
                        end
                    end
                end
                results_seen++;
            end
            // a write lands after this edge; clamp gains above unity
            if (i_cfg_we) begin
                gain_copy = 32'((i_cfg_data > GAIN_ONE) ? GAIN_ONE : i_cfg_data);
            end
        end
        pending = blended_q.size();
    end

endmodule

// ----- tb/sv/premultiplied_alpha_blend_x4_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// premultiplied_alpha_blend_x4_top_test
// Drives requests of four source and four destination pixels into the over
// compositor under several alpha gains and idle/stall mixes; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module premultiplied_alpha_blend_x4_top_test;
    import pmab_pkg::*;

    localparam int NUM_DIRECTED   = 12;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_REQUESTS = 231;
    localparam int DRAIN_CYCLES   = 4;

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              cfg_we     = 1'b0;
    logic [GAIN_W-1:0]                 cfg_data   = '0;
    logic                              in_valid   = 1'b0;
    logic                              in_stall;
    logic [NUM_LANES-1:0][PIXEL_W-1:0] src_pixels = '0;
    logic [NUM_LANES-1:0][PIXEL_W-1:0] dst_pixels = '0;
    logic                              out_valid;
    logic                              out_stall  = 1'b0;
    logic [NUM_LANES-1:0][PIXEL_W-1:0] out_pixels;

    int mismatch_count;
    int results_pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    logic [PIXEL_W-1:0] corner_src [NUM_DIRECTED] = '{
        32'h00000000, 32'hFFFFFFFF, 32'hFF123456, 32'h00FFFFFF,
        32'h80808080, 32'h10FFFFFF, 32'h80402010, 32'h01010101,
        32'hFE7F3F00, 32'h00000000, 32'hFF000000, 32'h7F7F7F7F
    };
    logic [PIXEL_W-1:0] corner_dst [NUM_DIRECTED] = '{
        32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000,
        32'h80808080, 32'hFFFFFFFF, 32'hA5A5A5A5, 32'h5A5A5A5A,
        32'hFF00FF00, 32'h12345678, 32'h00FF00FF, 32'hFFFFFFFF
    };

    int phase_gain  [NUM_PHASES] = '{511, 0, 1, 128, 255, 256, 0, 257};
    int phase_idle  [NUM_PHASES] = '{0, 75, 0, 28, 0, 75, 0, 28};
    int phase_stall [NUM_PHASES] = '{0, 0, 75, 28, 0, 0, 75, 28};

    premultiplied_alpha_blend_x4_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_src_pixel_0 (src_pixels[0]),
        .i_src_pixel_1 (src_pixels[1]),
        .i_src_pixel_2 (src_pixels[2]),
        .i_src_pixel_3 (src_pixels[3]),
        .i_dst_pixel_0 (dst_pixels[0]),
        .i_dst_pixel_1 (dst_pixels[1]),
        .i_dst_pixel_2 (dst_pixels[2]),
        .i_dst_pixel_3 (dst_pixels[3]),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_pixel_0 (out_pixels[0]),
        .o_out_pixel_1 (out_pixels[1]),
        .o_out_pixel_2 (out_pixels[2]),
        .o_out_pixel_3 (out_pixels[3])
    );

    premultiplied_alpha_blend_x4_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_src_pixels      (src_pixels),
        .i_dst_pixels      (dst_pixels),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_pixels      (out_pixels),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Mostly premultiplied sources, plus opaque, clear and raw words.
    function automatic logic [PIXEL_W-1:0] random_source();
        logic [PIXEL_W-1:0] pix;
        logic [CHAN_W-1:0]  alpha;
        int                 kind;
        kind  = $urandom_range(9, 0);
        alpha = CHAN_W'($urandom);
        pix   = $urandom;
        case (kind)
            0, 1, 2, 3, 4: begin
                if (kind == 0) begin
                    alpha = ($urandom_range(1, 0) != 0) ? CHAN_MAX : '0;
                end
                pix[PIXEL_W-1 -: CHAN_W] = alpha;
                for (int ch = 0; ch < CHANNELS - 1; ch++) begin
                    pix[ch*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(alpha, 0));
                end
            end
            5: pix[PIXEL_W-1 -: CHAN_W] = CHAN_MAX;
            6: pix = '0;
            7: pix[PIXEL_W-1 -: CHAN_W] = '0;
            default: ;
        endcase
        return pix;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_dest();
        int kind;
        kind = $urandom_range(7, 0);
        if (kind == 0) begin
            return '0;
        end else if (kind == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic send_request(input logic [NUM_LANES-1:0][PIXEL_W-1:0] src,
                                input logic [NUM_LANES-1:0][PIXEL_W-1:0] dst);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        src_pixels <= src;
        dst_pixels <= dst;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic send_corner(input int idx);
        logic [NUM_LANES-1:0][PIXEL_W-1:0] src;
        logic [NUM_LANES-1:0][PIXEL_W-1:0] dst;
        for (int ln = 0; ln < NUM_LANES; ln++) begin
            src[ln] = corner_src[(idx + ln) % NUM_DIRECTED];
            dst[ln] = corner_dst[(idx + 3 * ln) % NUM_DIRECTED];
        end
        send_request(src, dst);
    endtask

    task automatic send_random();
        logic [NUM_LANES-1:0][PIXEL_W-1:0] src;
        logic [NUM_LANES-1:0][PIXEL_W-1:0] dst;
        for (int ln = 0; ln < NUM_LANES; ln++) begin
            src[ln] = random_source();
            dst[ln] = random_dest();
        end
        send_request(src, dst);
    endtask

    // Hold the sender until every result is back, then let the pipe settle.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner pixels at the reset gain, no idling
        for (int k = 0; k < NUM_DIRECTED; k++) begin
            send_corner(k);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drain();
            if (ph == 6) begin
                write_gain(GAIN_W'($urandom_range(511, 0)));
            end else begin
                write_gain(GAIN_W'(phase_gain[ph]));
            end
            send_idle_pct = phase_idle[ph];
            stall_pct     = phase_stall[ph];
            send_corner(ph);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (ph == 3 && n == PHASE_REQUESTS / 2) begin
                    wait_drain();
                end
                send_random();
            end
        end

        wait_drain();
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("premultiplied_alpha_blend_x4_top_test OK");
        end else begin
            $display("premultiplied_alpha_blend_x4_top_test NOT OK");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("premultiplied_alpha_blend_x4_top_test NOT OK");
        $finish;
    end

endmodule
